// File: rtl/csv_field_parser_core_assert.svh
// assertion macros used by the csv field parser back emitter
`ifndef CSV_FIELD_PARSER_CORE_ASSERT_SVH
`define CSV_FIELD_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property that holds on every clock out of reset
`define CSVFP_ASSERT_HOLDS(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("csvfp: invariant violated");
// same-cycle implication
`define CSVFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvfp: implication violated");
`else
`define CSVFP_ASSERT_HOLDS(label, prop)
`define CSVFP_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// File: rtl/csvfp_pkg.sv
package csvfp_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP = 8'h20;

  // trailing whitespace buffer
  localparam int WS_DEPTH = 16;
  localparam int WS_IDX_W = $clog2(WS_DEPTH);
  localparam int WS_CNT_W = $clog2(WS_DEPTH + 1);

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic CFG_QUOTE = 1'b0;
  localparam logic CFG_SEPARATOR = 1'b1;

  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE          = 2'd0,
    ERR_EOF_IN_QUOTES = 2'd1,
    ERR_STRAY_BYTE    = 2'd2,
    ERR_WS_OVERFLOW   = 2'd3
  } err_t;

  // one command from the classifier to the emitter
  typedef struct packed {
    logic        store;  // append data to whitespace buffer, no result
    logic        flush;  // release buffered whitespace before the result
    kind_t       kind;
    logic [7:0]  data;
    err_t        code;
    logic [23:0] line;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

// File: rtl/csvfp_front.sv
module csvfp_front import csvfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  typedef enum logic [6:0] {
    ST_ROW    = 7'b0000001,
    ST_FIELD  = 7'b0000010,
    ST_UNQ    = 7'b0000100,
    ST_QUOTED = 7'b0001000,
    ST_QSEEN  = 7'b0010000,
    ST_AFTERQ = 7'b0100000,
    ST_HALT   = 7'b1000000
  } pstate_t;

  pstate_t             state_r, state_nxt, s_eff;
  logic                cr_r, cr_nxt;
  logic [WS_CNT_W-1:0] pc_r, pc_nxt;
  logic [23:0]         line_r, line_nxt, line_inc;
  logic [7:0]          quote_r, sep_r;
  logic [7:0]          bb;
  logic                acc, eof, is_lf, ws;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign eof       = in_action;
  assign line_inc  = (line_r == LINE_MAX) ? line_r : line_r + 24'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= 8'd34;
      sep_r   <= 8'd44;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_QUOTE:     quote_r <= cfg_data;
        CFG_SEPARATOR: sep_r   <= cfg_data;
        default:       ;
      endcase
    end
  end

  // classify one beat and update parse state
  always_comb begin
    state_nxt = state_r;
    cr_nxt    = cr_r;
    pc_nxt    = pc_r;
    line_nxt  = line_r;
    push      = 1'b0;
    push_cmd  = '{store: 1'b0, flush: 1'b0, kind: KIND_CONTENT, data: 8'h00,
                  code: ERR_NONE, line: line_r};
    bb        = eof ? 8'h00 : in_data_byte;
    is_lf     = 1'b0;
    ws        = 1'b0;
    s_eff     = state_r;
    if (acc && state_r != ST_HALT) begin
      cr_nxt = 1'b0;
      // lf right after a cr that acted as newline is swallowed
      if (!(cr_r && !eof && in_data_byte == CH_LF)) begin
        if (!eof && in_data_byte == CH_CR &&
            (state_r == ST_ROW || state_r == ST_FIELD ||
             state_r == ST_UNQ || state_r == ST_QSEEN)) begin
          bb     = CH_LF;
          cr_nxt = 1'b1;
        end
        is_lf = !eof && (bb == CH_LF);
        ws    = !eof && is_ws(bb);
        // fall-through transitions resolved before acting
        if (s_eff == ST_ROW && !eof && !is_lf) begin
          s_eff = ST_FIELD;
        end
        if (s_eff == ST_FIELD && !eof && !is_lf && !ws && bb != quote_r) begin
          s_eff = ST_UNQ;
        end
        if (s_eff == ST_QSEEN && (eof || bb != quote_r)) begin
          s_eff = ST_AFTERQ;
        end
        state_nxt = s_eff;
        unique case (s_eff)
          ST_ROW: begin
            if (is_lf) begin
              line_nxt = line_inc;
            end
          end
          ST_FIELD: begin
            if (eof || is_lf) begin
              push          = 1'b1;
              push_cmd.kind = KIND_ROW_END;
              line_nxt      = line_inc;
              pc_nxt        = '0;
              state_nxt     = ST_ROW;
            end else if (!ws) begin
              state_nxt = ST_QUOTED;
            end
          end
          ST_UNQ: begin
            push = 1'b1;
            if (eof || is_lf) begin
              push_cmd.kind = KIND_ROW_END;
              line_nxt      = line_inc;
              pc_nxt        = '0;
              state_nxt     = ST_ROW;
            end else if (bb == sep_r) begin
              push_cmd.kind = KIND_FIELD_END;
              pc_nxt        = '0;
              state_nxt     = ST_FIELD;
            end else if (ws) begin
              if (pc_r >= WS_CNT_W'(WS_DEPTH)) begin
                push_cmd.kind = KIND_ERROR;
                push_cmd.code = ERR_WS_OVERFLOW;
                pc_nxt        = '0;
                state_nxt     = ST_HALT;
              end else begin
                push_cmd.store = 1'b1;
                push_cmd.data  = bb;
                pc_nxt         = pc_r + WS_CNT_W'(1);
              end
            end else begin
              push_cmd.flush = 1'b1;
              push_cmd.data  = bb;
              pc_nxt         = '0;
            end
          end
          ST_QUOTED: begin
            if (eof) begin
              push          = 1'b1;
              push_cmd.kind = KIND_ERROR;
              push_cmd.code = ERR_EOF_IN_QUOTES;
              pc_nxt        = '0;
              state_nxt     = ST_HALT;
            end else if (bb == quote_r) begin
              state_nxt = ST_QSEEN;
            end else begin
              push          = 1'b1;
              push_cmd.data = bb;
              if (is_lf) begin
                line_nxt = line_inc;
              end
            end
          end
          ST_QSEEN: begin
            // doubled quote
            push          = 1'b1;
            push_cmd.data = bb;
            state_nxt     = ST_QUOTED;
          end
          ST_AFTERQ: begin
            if (eof || is_lf) begin
              push          = 1'b1;
              push_cmd.kind = KIND_ROW_END;
              line_nxt      = line_inc;
              pc_nxt        = '0;
              state_nxt     = ST_ROW;
            end else if (bb == sep_r) begin
              push          = 1'b1;
              push_cmd.kind = KIND_FIELD_END;
              state_nxt     = ST_FIELD;
            end else if (!ws) begin
              push          = 1'b1;
              push_cmd.kind = KIND_ERROR;
              push_cmd.code = ERR_STRAY_BYTE;
              pc_nxt        = '0;
              state_nxt     = ST_HALT;
            end
          end
          default: state_nxt = ST_HALT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ROW;
      cr_r    <= 1'b0;
      pc_r    <= '0;
      line_r  <= 24'd1;
    end else begin
      state_r <= state_nxt;
      cr_r    <= cr_nxt;
      pc_r    <= pc_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// File: rtl/csvfp_queue.sv
module csvfp_queue import csvfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_r + Q_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/csvfp_back.sv
`include "csv_field_parser_core_assert.svh"

module csvfp_back import csvfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_content_byte,
  output logic [1:0]  out_error_code,
  output logic [23:0] out_line_number,
  output logic        out_last
);

  logic [7:0]          ws_mem_r [WS_DEPTH];
  logic [WS_CNT_W-1:0] cnt_r, cnt_nxt, fi_r, fi_nxt;
  logic                wr_en, load, room;
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, kind_nxt;
  logic [7:0]          out_data_r, data_nxt;
  err_t                out_code_r, code_nxt;
  logic [23:0]         out_line_r;
  logic                out_last_r, last_nxt;

  assign room = !out_valid_r || out_ready;

  // execute the queue head: buffer whitespace or release results
  always_comb begin
    pop           = 1'b0;
    wr_en         = 1'b0;
    load          = 1'b0;
    cnt_nxt       = cnt_r;
    fi_nxt        = fi_r;
    kind_nxt      = head.kind;
    data_nxt      = head.data;
    code_nxt      = head.code;
    last_nxt      = 1'b1;
    out_valid_nxt = out_valid_r && !out_ready;
    if (head_valid) begin
      if (head.store) begin
        pop     = 1'b1;
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + WS_CNT_W'(1);
      end else if (room) begin
        load          = 1'b1;
        out_valid_nxt = 1'b1;
        if (head.flush && fi_r < cnt_r) begin
          kind_nxt = KIND_CONTENT;
          data_nxt = ws_mem_r[fi_r[WS_IDX_W-1:0]];
          code_nxt = ERR_NONE;
          last_nxt = 1'b0;
          fi_nxt   = fi_r + WS_CNT_W'(1);
        end else begin
          pop     = 1'b1;
          fi_nxt  = '0;
          cnt_nxt = '0;
        end
      end
    end
  end

  // whitespace buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ws_mem_r[cnt_r[WS_IDX_W-1:0]] <= head.data;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= kind_nxt;
      out_data_r <= data_nxt;
      out_code_r <= code_nxt;
      out_line_r <= head.line;
      out_last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      fi_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      fi_r        <= fi_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_content_byte = out_data_r;
  assign out_error_code   = out_code_r;
  assign out_line_number  = out_line_r;
  assign out_last         = out_last_r;

  // checks
  `CSVFP_ASSERT_HOLDS(a_ws_cnt_bound, cnt_r <= WS_CNT_W'(WS_DEPTH))
  `CSVFP_ASSERT_HOLDS(a_flush_idx_bound, fi_r <= cnt_r)
  `CSVFP_ASSERT_IMPL(a_inner_beat_content, out_valid_r && !out_last_r, out_kind_r == KIND_CONTENT)

endmodule

// File: rtl/csv_field_parser_core.sv
// csv field parser
// in channel: one beat per input byte (in_action 0, byte on in_data_byte) or an
//   end-of-input mark (in_action 1). out channel: content bytes, field ends,
//   row ends and errors, each tagged with its line number; out_last marks the
//   final result of an input beat. cfg channel: index 0 quote, 1 separator,
//   always ready; user must write it only while the block is idle (not enforced).
// a front classifier takes one input beat per cycle, while the two-entry command
//   queue has room; the back emitter turns each command into results, one per
//   cycle while out_ready allows. a beat's first result reaches the out ports
//   through the command queue and then the emitter's output register. a beat
//   that only buffers whitespace yields no result; a beat that releases n buffered
//   whitespace bytes yields n + 1 results, so the output register sets the pace.
// stall: when out_ready is low the result holds, the queue fills and
//   in_ready drops after two more commands.
// reset: synchronous, rst_n low; row start, line 1, quote 34, separator 44.
// after an error result the block swallows all input until reset.
module csv_field_parser_core import csvfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_content_byte,
  output logic [1:0]  out_error_code,
  output logic [23:0] out_line_number,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic push, q_full, pop, head_valid;
  cmd_t push_cmd, head;

  csvfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  csvfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  csvfp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_content_byte (out_content_byte),
    .out_error_code   (out_error_code),
    .out_line_number  (out_line_number),
    .out_last         (out_last)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import csvfp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 100;
  localparam int HOLD_AFTER = 150;
  localparam int ITEMS_PER_PHASE = 40;

  // parser states of the predictor
  typedef enum logic [2:0] {
    PS_ROW, PS_FIELD, PS_UNQ, PS_QUOTED, PS_QSEEN, PS_AFTERQ, PS_HALT
  } parse_state_t;

  typedef struct packed {
    parse_state_t        st;
    logic                cr_seen;
    logic [15:0][7:0]    ws_buf;
    logic [4:0]          ws_cnt;
    logic [23:0]         line;
    logic [7:0]          quote;
    logic [7:0]          sep;
  } parser_ctx_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    err_t        code;
    logic [23:0] line;
    logic        last;
  } token_t;

  typedef token_t token_list_t[$];

  typedef struct packed {
    logic       eof;
    logic [7:0] data;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_content_byte;
  logic [1:0]  out_error_code;
  logic [23:0] out_line_number;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  csv_field_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_content_byte (out_content_byte),
    .out_error_code   (out_error_code),
    .out_line_number  (out_line_number),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  parser_ctx_t   live_ctx;
  parser_ctx_t   gen_ctx;
  stream_item_t  stream_q[$];
  token_t        tokens_due[$];
  int unsigned   items_queued = 0;
  int unsigned   items_taken = 0;
  int unsigned   fails = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   hold_left = 0;
  bit            hold_done = 1'b0;
  int            idle_mode = 0;

  // whitespace class of the csv grammar
  function automatic bit blank_byte(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic parser_ctx_t ctx_after_reset();
    parser_ctx_t c;
    c = '0;
    c.st = PS_ROW;
    c.line = 24'd1;
    c.quote = 8'd34;
    c.sep = 8'd44;
    return c;
  endfunction

  function automatic token_t mk_token(kind_t k, logic [7:0] d, err_t e, logic [23:0] ln);
    token_t t;
    t.kind = k;
    t.data = d;
    t.code = e;
    t.line = ln;
    t.last = 1'b0;
    return t;
  endfunction

  // advances the parser context by one beat and returns the tokens it makes
  function automatic token_list_t parse_step(inout parser_ctx_t c, input logic eof,
                                             input logic [7:0] din);
    token_list_t outs;
    logic [7:0]  b;
    bit          again;
    b = din;
    if (c.st == PS_HALT) return outs;
    // lf straight after a cr that already acted as newline
    if (c.cr_seen) begin
      c.cr_seen = 1'b0;
      if (!eof && b == CH_LF) return outs;
    end
    if (eof) b = 8'h00;
    if (!eof && b == CH_CR && (c.st == PS_ROW || c.st == PS_FIELD ||
                               c.st == PS_UNQ || c.st == PS_QSEEN)) begin
      b = CH_LF;
      c.cr_seen = 1'b1;
    end
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (c.st)
        PS_ROW: begin
          if (!eof) begin
            if (b == CH_LF) begin
              if (c.line != LINE_MAX) c.line++;
            end else begin
              c.st = PS_FIELD;
              again = 1'b1;
            end
          end
        end
        PS_FIELD: begin
          if (eof || b == CH_LF) begin
            c.ws_cnt = '0;
            outs.push_back(mk_token(KIND_ROW_END, 8'h00, ERR_NONE, c.line));
            if (c.line != LINE_MAX) c.line++;
            c.st = PS_ROW;
          end else if (blank_byte(b)) begin
          end else if (b == c.quote) begin
            c.st = PS_QUOTED;
          end else begin
            c.st = PS_UNQ;
            again = 1'b1;
          end
        end
        PS_UNQ: begin
          if (eof || b == CH_LF) begin
            c.ws_cnt = '0;
            outs.push_back(mk_token(KIND_ROW_END, 8'h00, ERR_NONE, c.line));
            if (c.line != LINE_MAX) c.line++;
            c.st = PS_ROW;
          end else if (b == c.sep) begin
            c.ws_cnt = '0;
            outs.push_back(mk_token(KIND_FIELD_END, 8'h00, ERR_NONE, c.line));
            c.st = PS_FIELD;
          end else if (blank_byte(b)) begin
            // trailing whitespace is held until a data byte proves it inner
            if (c.ws_cnt >= WS_DEPTH) begin
              c.ws_cnt = '0;
              outs.push_back(mk_token(KIND_ERROR, 8'h00, ERR_WS_OVERFLOW, c.line));
              c.st = PS_HALT;
            end else begin
              c.ws_buf[c.ws_cnt[3:0]] = b;
              c.ws_cnt++;
            end
          end else begin
            for (int i = 0; i < c.ws_cnt; i++)
              outs.push_back(mk_token(KIND_CONTENT, c.ws_buf[i], ERR_NONE, c.line));
            c.ws_cnt = '0;
            outs.push_back(mk_token(KIND_CONTENT, b, ERR_NONE, c.line));
          end
        end
        PS_QUOTED: begin
          if (eof) begin
            c.ws_cnt = '0;
            outs.push_back(mk_token(KIND_ERROR, 8'h00, ERR_EOF_IN_QUOTES, c.line));
            c.st = PS_HALT;
          end else if (b == c.quote) begin
            c.st = PS_QSEEN;
          end else begin
            outs.push_back(mk_token(KIND_CONTENT, b, ERR_NONE, c.line));
            if (b == CH_LF && c.line != LINE_MAX) c.line++;
          end
        end
        PS_QSEEN: begin
          // doubled quote stands for one quote
          if (!eof && b == c.quote) begin
            outs.push_back(mk_token(KIND_CONTENT, b, ERR_NONE, c.line));
            c.st = PS_QUOTED;
          end else begin
            c.st = PS_AFTERQ;
            again = 1'b1;
          end
        end
        PS_AFTERQ: begin
          if (eof || b == CH_LF) begin
            c.ws_cnt = '0;
            outs.push_back(mk_token(KIND_ROW_END, 8'h00, ERR_NONE, c.line));
            if (c.line != LINE_MAX) c.line++;
            c.st = PS_ROW;
          end else if (b == c.sep) begin
            outs.push_back(mk_token(KIND_FIELD_END, 8'h00, ERR_NONE, c.line));
            c.st = PS_FIELD;
          end else if (blank_byte(b)) begin
          end else begin
            c.ws_cnt = '0;
            outs.push_back(mk_token(KIND_ERROR, 8'h00, ERR_STRAY_BYTE, c.line));
            c.st = PS_HALT;
          end
        end
        default: c.st = PS_HALT;
      endcase
    end
    if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
    return outs;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    fails++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic int tx_idle_pct();
    return (idle_mode == 0) ? 28 : (idle_mode == 1) ? 61 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (idle_mode == 0) ? 61 : (idle_mode == 1) ? 28 : 0;
  endfunction

  // input driver: predicts on every accepted beat, then loads the next one
  always @(posedge clk) begin : drive_in
    stream_item_t cur;
    token_list_t  fresh;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fresh = parse_step(live_ctx, in_action, in_data_byte);
        foreach (fresh[i]) tokens_due.push_back(fresh[i]);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
          cur = stream_q.pop_front();
          in_valid <= 1'b1;
          in_action <= cur.eof;
          in_data_byte <= cur.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off so the block backs up into its input
  always @(posedge clk) begin : hold_off
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && items_taken >= HOLD_AFTER && stream_q.size() > 8) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : watch_out
    token_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          report("result with none expected, kind", out_kind, 0);
        end else begin
          want = tokens_due.pop_front();
          if (out_kind !== want.kind) report("kind", out_kind, want.kind);
          if (out_content_byte !== want.data) report("content_byte", out_content_byte, want.data);
          if (out_error_code !== want.code) report("error_code", out_error_code, want.code);
          if (out_line_number !== want.line) report("line_number", out_line_number, want.line);
          if (out_last !== want.last) report("last", out_last, want.last);
        end
      end
      // receiver held off for the whole hold-off stretch
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct());
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("** csv_field_parser_core: FAILED **");
        $finish;
      end
    end
  end

  // queue a beat unless it would halt the parser where that is not wanted
  task automatic offer(logic eof, logic [7:0] b, bit allow_err);
    parser_ctx_t  trial;
    token_list_t  scratch;
    stream_item_t it;
    trial = gen_ctx;
    scratch = parse_step(trial, eof, b);
    if (trial.st == PS_HALT && !allow_err) return;
    gen_ctx = trial;
    it.eof = eof;
    it.data = b;
    stream_q.push_back(it);
    items_queued++;
  endtask

  task automatic put(logic [7:0] b);
    offer(1'b0, b, 1'b0);
  endtask

  task automatic put_eof();
    offer(1'b1, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic logic [7:0] pick_blank();
    logic [7:0] pool [6];
    pool = '{8'h20, 8'h20, 8'h09, 8'h0B, 8'h0C, 8'h20};
    return pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] pick_text();
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(33, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_newline();
    case ($urandom_range(0, 2))
      0: put(CH_LF);
      1: put(CH_CR);
      default: begin
        put(CH_CR);
        put(CH_LF);
      end
    endcase
  endtask

  task automatic gen_field();
    int n;
    repeat ($urandom_range(0, 2)) put(pick_blank());
    if ($urandom_range(0, 99) < 30) begin
      // quoted field with doubled quotes and embedded newlines
      put(gen_ctx.quote);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            put(gen_ctx.quote);
            put(gen_ctx.quote);
          end
          2: put($urandom_range(0, 1) ? CH_LF : CH_CR);
          default: put(pick_text());
        endcase
      end
      put(gen_ctx.quote);
      if ($urandom_range(0, 99) < 20) put(pick_blank());
    end else begin
      n = $urandom_range(0, 5);
      repeat (n) put(($urandom_range(0, 99) < 20) ? pick_blank() : pick_text());
      case ($urandom_range(0, 19))
        0: repeat ($urandom_range(14, 17)) put(pick_blank());
        1, 2, 3: repeat ($urandom_range(1, 3)) put(pick_blank());
        default: ;
      endcase
      if ($urandom_range(0, 99) < 15) put(pick_text());
    end
  endtask

  task automatic gen_phase(int n_items);
    int unsigned start;
    int          r;
    int          nf;
    start = items_queued;
    while (items_queued - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 19) == 0) put_eof();
          else put(8'($urandom_range(0, 255)));
        end
      end else if (r < 14) begin
        repeat ($urandom_range(1, 2)) put_newline();
      end else begin
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
          if (f != 0) put(gen_ctx.sep);
          gen_field();
        end
        if ($urandom_range(0, 9) == 0) put_eof();
        else put_newline();
      end
    end
    // close any open quote and end the stream at row start
    while (gen_ctx.st == PS_QUOTED) put(gen_ctx.quote);
    put_eof();
  endtask

  // wait until every beat is in and every result is out, then let the block settle
  task automatic settle();
    while (items_taken != items_queued || tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_QUOTE) begin
      live_ctx.quote = val;
      gen_ctx.quote = val;
    end else begin
      live_ctx.sep = val;
      gen_ctx.sep = val;
    end
  endtask

  initial begin
    logic [7:0] quote_set [8];
    logic [7:0] sep_set [8];
    live_ctx = ctx_after_reset();
    gen_ctx = ctx_after_reset();
    // extremes, quote equal to separator, blank quote and separator, newline codes
    quote_set = '{8'd0, 8'd255, 8'd59, 8'h20, CH_LF, CH_CR, 8'd0, 8'd39};
    sep_set   = '{8'd255, 8'd0, 8'd59, 8'h09, CH_CR, CH_LF, 8'd0, 8'd124};
    quote_set[6] = 8'($urandom_range(0, 255));
    sep_set[6] = 8'($urandom_range(0, 255));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under reset settings
    idle_mode = 0;
    put(8'h20);          // leading blank skipped
    put("a");
    put(8'h20);          // held, then released by the next data byte
    put(8'h00);
    put(CH_TAB);         // trailing blank dropped at separator
    put(",");
    put(8'd34);
    put(8'd34);
    put(8'd34);          // doubled quote
    put(CH_LF);          // newline inside quotes
    put(CH_CR);
    put(8'd34);
    put(8'h20);          // blank after closing quote
    put(CH_CR);          // raw cr after closing quote is a blank
    put(",");
    put(CH_CR);          // cr closes the row with an empty field
    put(CH_LF);          // dropped lf of crlf
    put(CH_CR);          // empty line
    put(CH_CR);
    put(CH_TAB);         // blank-only line
    put_eof();
    put_eof();           // end of input at row start
    put(8'd34);
    put("x");
    put(8'd34);
    put_eof();           // end of input after closing quote
    put(8'hFF);
    put_eof();
    settle();

    // random phases over the register settings
    for (int p = 0; p < 8; p++) begin
      idle_mode = (p < 3) ? 0 : (p < 6) ? 1 : 2;
      cfg_write(CFG_QUOTE, quote_set[p]);
      cfg_write(CFG_SEPARATOR, sep_set[p]);
      gen_phase(ITEMS_PER_PHASE);
      settle();
    end

    // one terminal error, the block then ignores everything
    cfg_write(CFG_QUOTE, 8'd34);
    cfg_write(CFG_SEPARATOR, 8'd44);
    case ($urandom_range(0, 2))
      0: begin
        offer(1'b0, 8'd34, 1'b1);
        offer(1'b0, "q", 1'b1);
        offer(1'b1, 8'h00, 1'b1);
      end
      1: begin
        offer(1'b0, 8'd34, 1'b1);
        offer(1'b0, "q", 1'b1);
        offer(1'b0, 8'd34, 1'b1);
        offer(1'b0, "z", 1'b1);
      end
      default: begin
        offer(1'b0, "w", 1'b1);
        repeat (WS_DEPTH + 1) offer(1'b0, 8'h20, 1'b1);
      end
    endcase
    offer(1'b0, "b", 1'b1);
    offer(1'b0, CH_LF, 1'b1);
    offer(1'b1, 8'h00, 1'b1);
    settle();

    if (fails == 0) begin
      $display("** csv_field_parser_core: PASSED **");
    end else begin
      $display("** csv_field_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
